### rtl/core/move_to_front_transform_assert.svh
// assertion macros used by the move-to-front transform top level
`ifndef MOVE_TO_FRONT_TRANSFORM_ASSERT_SVH
`define MOVE_TO_FRONT_TRANSFORM_ASSERT_SVH

// same-cycle implication, sampled on aclk, off while aresetn is low
`define MTFT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on aclk, off while aresetn is low
`define MTFT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/mtft_pkg.sv
// shared constants and types of the move-to-front transform
package mtft_pkg;

    localparam int ALPHABET_MAX = 256;
    localparam int SYM_W        = $clog2(ALPHABET_MAX);
    localparam int CNT_W        = 9;

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(ALPHABET_MAX);

    localparam logic ACT_ENCODE = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // wave that walks down the cell chain, one cell per cycle
    typedef struct packed {
        logic             vld;
        logic             found;
        logic [SYM_W-1:0] carry;
        logic [SYM_W-1:0] value;
    } tok_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic             restore;
        logic             mode;
        logic [SYM_W-1:0] key;
    } cell_ctrl_t;

endpackage

### rtl/core/mtft_cell.sv
// one list position: holds a symbol and swaps it with the passing wave
module mtft_cell
    import mtft_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [SYM_W-1:0] cell_idx,
    input  cell_ctrl_t       ctrl,
    input  logic             front_we,
    input  logic [SYM_W-1:0] front_sym,
    input  tok_t             tok_in,
    output tok_t             tok_out
);

    logic [SYM_W-1:0] sym_reg;
    logic [SYM_W-1:0] sym_next;
    tok_t             tok_reg;
    tok_t             tok_next;
    logic             swap;
    logic             hit;

    // before the target is found every cell hands its symbol one place down
    assign swap = tok_in.vld && !tok_in.found;
    assign hit  = swap && ((ctrl.mode == ACT_DECODE) ? (cell_idx == ctrl.key)
                                                    : (sym_reg == ctrl.key));

    always_comb begin
        sym_next = sym_reg;
        if (ctrl.restore) begin
            sym_next = cell_idx;
        end else if (front_we) begin
            sym_next = front_sym;
        end else if (swap) begin
            sym_next = tok_in.carry;
        end

        tok_next.vld   = tok_in.vld;
        tok_next.found = tok_in.found || hit;
        tok_next.carry = swap ? sym_reg : tok_in.carry;
        tok_next.value = tok_in.value;
        if (hit) begin
            tok_next.value = (ctrl.mode == ACT_DECODE) ? sym_reg : cell_idx;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sym_reg     <= cell_idx;
            tok_reg.vld <= 1'b0;
        end else begin
            sym_reg     <= sym_next;
            tok_reg.vld <= tok_next.vld;
        end
        tok_reg.found <= tok_next.found;
        tok_reg.carry <= tok_next.carry;
        tok_reg.value <= tok_next.value;
    end

    assign tok_out = tok_reg;

endmodule

### rtl/core/move_to_front_transform.sv
// move-to-front transform top level: controller and chain of list cells
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata = value_in[7:0], s_tuser = action
// m_       out  m_tvalid/m_tready  m_tdata = value_out[7:0], m_tuser = out_of_range
// cfg_     in   cfg_wr_en          cfg_wr_data = symbols_in_use[8:0]
//
// for an in-range item the wave crosses every cell
// of the chain, then the front cell is written and the result is registered
// an out-of-range item gives its result in the cycle after the transfer
// one item is in the chain at a time; a result that is not taken holds the
// chain result until m_tready; reset and a register write restore identity order
module move_to_front_transform
    import mtft_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,   // symbols_in_use[8:0]
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [SYM_W-1:0] s_tdata,       // value_in[7:0]
    input  logic             s_tuser,       // action
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [SYM_W-1:0] m_tdata,       // value_out[7:0]
    output logic             m_tuser        // out_of_range
);

    `include "move_to_front_transform_assert.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] n_use_reg, n_use_next;
    logic             mode_reg, mode_next;
    logic [SYM_W-1:0] key_reg, key_next;
    logic             launch_reg, launch_next;
    logic [SYM_W-1:0] pend_reg, pend_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [SYM_W-1:0] m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    logic             s_xfer;
    logic             oor;
    logic             out_free;
    logic             front_we;
    cell_ctrl_t       ctrl;
    tok_t             chain [0:ALPHABET_MAX];
    tok_t             tail;
    logic [ALPHABET_MAX-1:0] tok_vld_vec;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_xfer   = s_tvalid && s_tready;
    assign oor      = {1'b0, s_tdata} >= n_use_reg;
    assign tail     = chain[ALPHABET_MAX];
    assign front_we = (state_reg == ST_RUN) && tail.vld;

    assign ctrl.restore = cfg_wr_en;
    assign ctrl.mode    = mode_reg;
    assign ctrl.key     = key_reg;

    assign chain[0].vld   = launch_reg;
    assign chain[0].found = 1'b0;
    assign chain[0].carry = key_reg;
    assign chain[0].value = '0;

    for (genvar i = 0; i < ALPHABET_MAX; i++) begin : g_cell
        mtft_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (SYM_W'(i)),
            .ctrl      (ctrl),
            .front_we  ((i == 0) ? front_we : 1'b0),
            .front_sym (tail.carry),
            .tok_in    (chain[i]),
            .tok_out   (chain[i+1])
        );
        assign tok_vld_vec[i] = chain[i+1].vld;
    end

    always_comb begin
        state_next    = state_reg;
        n_use_next    = n_use_reg;
        mode_next     = mode_reg;
        key_next      = key_reg;
        launch_next   = 1'b0;
        pend_next     = pend_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;

        // register values above the alphabet saturate
        if (cfg_wr_en) begin
            n_use_next = (cfg_wr_data > CNT_MAX) ? CNT_MAX : cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    if (oor) begin
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = '0;
                        m_tuser_next  = 1'b1;
                    end else begin
                        mode_next   = s_tuser;
                        key_next    = s_tdata;
                        launch_next = 1'b1;
                        state_next  = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (tail.vld) begin
                    pend_next  = tail.value;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = pend_reg;
                    m_tuser_next  = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            n_use_reg    <= CNT_MAX;
            launch_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_use_reg    <= n_use_next;
            launch_reg   <= launch_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        mode_reg    <= mode_next;
        key_reg     <= key_next;
        pend_reg    <= pend_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `MTFT_ASSERT_IMP(a_single_wave, 1'b1, $onehot0(tok_vld_vec), "more than one wave in the chain")
    `MTFT_ASSERT_IMP(a_tail_in_run, tail.vld, state_reg == ST_RUN, "wave left the chain outside run")
    `MTFT_ASSERT_IMP(a_wave_found, tail.vld, tail.found, "wave crossed the chain without a hit")
    `MTFT_ASSERT_NXT(a_launch, s_xfer && !oor, state_reg == ST_RUN && launch_reg, "in-range item not launched")
    `MTFT_ASSERT_IMP(a_oor_zero, m_tvalid && m_tuser, m_tdata == '0, "flagged result carries data")

endmodule
